/* rtl/assert_macros.svh */
// Assertion macros used by the port-level checker of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, lhs, rhs) \
  label: assert property (@(posedge clk) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

/* rtl/u8u16_pkg.sv */
// Package with the types and constants of the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

  typedef logic [20:0] code_point_t;

  typedef struct packed {
    logic        valid;
    code_point_t cp;
  } cp_req_t;

  typedef struct packed {
    logic        avail;
    code_point_t cp;
  } cp_head_t;

  localparam code_point_t CP_MAX    = 21'h10FFFF;
  localparam code_point_t SUPP_BASE = 21'h010000;
  localparam logic [15:0] HI_BASE   = 16'hD800;
  localparam logic [15:0] LO_BASE   = 16'hDC00;

  localparam logic [2:0] LEN_IDLE  = 3'd0;
  localparam logic [2:0] LEN_TWO   = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR  = 3'd4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

endpackage

/* rtl/u8u16_front.sv */
// Front part: assembles UTF-8 bytes into code points and checks them.
module u8u16_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  output u8u16_pkg::cp_req_t  req
);
  import u8u16_pkg::*;

  logic [1:0]  bytes_remaining, bytes_remaining_next;
  logic [2:0]  sequence_length, sequence_length_next;
  code_point_t partial_code, partial_code_next;
  logic [3:0]  lead_low_bits, lead_low_bits_next;
  logic        cont;
  logic        first;
  logic        overlong;
  code_point_t cp_acc;

  assign cont     = (in_byte[7:6] == 2'b10);
  assign first    = (({1'b0, bytes_remaining} + 3'd1) == sequence_length);
  assign overlong = first && (lead_low_bits == 4'd0) &&
                    (((sequence_length == LEN_THREE) && !in_byte[5]) ||
                     ((sequence_length == LEN_FOUR) && (in_byte[5:4] == 2'b00)));
  assign cp_acc   = {partial_code[14:0], in_byte[5:0]};

  always_comb begin
    bytes_remaining_next = bytes_remaining;
    sequence_length_next = sequence_length;
    partial_code_next    = partial_code;
    lead_low_bits_next   = lead_low_bits;
    req                  = '0;
    if (accept) begin
      if (cont) begin
        if (bytes_remaining != 2'd0) begin
          if (overlong) begin
            bytes_remaining_next = 2'd0;
            sequence_length_next = LEN_IDLE;
            partial_code_next    = '0;
            lead_low_bits_next   = 4'd0;
          end else if (bytes_remaining == 2'd1) begin
            bytes_remaining_next = 2'd0;
            sequence_length_next = LEN_IDLE;
            partial_code_next    = '0;
            lead_low_bits_next   = 4'd0;
            req.valid            = (cp_acc <= CP_MAX);
            req.cp               = cp_acc;
          end else begin
            bytes_remaining_next = bytes_remaining - 2'd1;
            partial_code_next    = cp_acc;
          end
        end
      end else begin
        bytes_remaining_next = 2'd0;
        sequence_length_next = LEN_IDLE;
        partial_code_next    = '0;
        lead_low_bits_next   = 4'd0;
        if (!in_byte[7]) begin
          req.valid = 1'b1;
          req.cp    = {13'd0, in_byte};
        end else if (in_byte inside {[8'hC2:8'hDF]}) begin
          sequence_length_next = LEN_TWO;
          bytes_remaining_next = 2'd1;
          lead_low_bits_next   = in_byte[3:0];
          partial_code_next    = {16'd0, in_byte[4:0]};
        end else if (in_byte inside {[8'hE0:8'hEF]}) begin
          sequence_length_next = LEN_THREE;
          bytes_remaining_next = 2'd2;
          lead_low_bits_next   = in_byte[3:0];
          partial_code_next    = {17'd0, in_byte[3:0]};
        end else if (in_byte inside {[8'hF0:8'hF7]}) begin
          sequence_length_next = LEN_FOUR;
          bytes_remaining_next = 2'd3;
          lead_low_bits_next   = {1'b0, in_byte[2:0]};
          partial_code_next    = {18'd0, in_byte[2:0]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= 2'd0;
      sequence_length <= LEN_IDLE;
      partial_code    <= '0;
      lead_low_bits   <= 4'd0;
    end else begin
      bytes_remaining <= bytes_remaining_next;
      sequence_length <= sequence_length_next;
      partial_code    <= partial_code_next;
      lead_low_bits   <= lead_low_bits_next;
    end
  end

endmodule

/* rtl/u8u16_queue.sv */
// Short queue of code points between the front and back parts.
module u8u16_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  u8u16_pkg::cp_req_t   wr,
  input  logic                 rd,
  output logic                 full,
  output u8u16_pkg::cp_head_t  head
);
  import u8u16_pkg::*;

  code_point_t               mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]       wr_ptr;
  logic [QUEUE_AW-1:0]       rd_ptr;
  logic [QUEUE_AW:0]         count;
  logic                      do_wr;
  logic                      do_rd;

  assign full      = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head.avail = (count != '0);
  assign head.cp   = mem[rd_ptr];
  assign do_wr     = wr.valid && !full;
  assign do_rd     = rd && head.avail;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr.cp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/u8u16_back.sv */
// Back part: turns code points into UTF-16 code units, one unit per cycle while pop is high.
module u8u16_back (
  input  logic                 clk,
  input  logic                 rst,
  input  u8u16_pkg::cp_head_t  head,
  output logic                 rd,
  output logic                 empty,
  input  logic                 pop,
  output logic [15:0]          code_unit,
  output logic                 last_unit
);
  import u8u16_pkg::*;

  logic        cur_valid;
  code_point_t cur_cp;
  logic        second_half;
  logic        big;
  code_point_t diff;
  logic        advance;

  assign big  = (cur_cp >= SUPP_BASE);
  assign diff = cur_cp - SUPP_BASE;

  always_comb begin
    if (!big) begin
      code_unit = cur_cp[15:0];
      last_unit = 1'b1;
    end else if (!second_half) begin
      code_unit = HI_BASE + {6'd0, diff[19:10]};
      last_unit = 1'b0;
    end else begin
      code_unit = LO_BASE + {6'd0, diff[9:0]};
      last_unit = 1'b1;
    end
  end

  assign empty   = !cur_valid;
  assign advance = !cur_valid || (pop && last_unit);
  assign rd      = advance;

  always_ff @(posedge clk) begin
    if (advance) begin
      cur_cp <= head.cp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid   <= 1'b0;
      second_half <= 1'b0;
    end else if (advance) begin
      cur_valid   <= head.avail;
      second_half <= 1'b0;
    end else if (pop) begin
      second_half <= 1'b1;
    end
  end

endmodule

/* rtl/utf8_to_utf16_decoder.sv */
// Top level of the UTF-8 to UTF-16 transcoder.
//
//   Channel   Handshake             Fields
//   input     push / full           in_byte[7:0]
//   result    empty / pop           code_unit[15:0], last_unit
//
// A byte is taken every cycle while the code point queue has room; the front
// part decodes it in the cycle it is taken. The back part gives one code unit
// per cycle while pop is high, so a character above the BMP gives a surrogate pair.
// When idle, a code point goes through the queue and then the output register.
// Reset clears the sequence state, queue pointers and count, and output valid.
// A stalled result side fills the four-entry queue and then raises full.
module utf8_to_utf16_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] code_unit,
  output logic        last_unit
);
  import u8u16_pkg::*;

  cp_req_t  req;
  cp_head_t head;
  logic     rd;

  u8u16_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (push && !full),
    .in_byte (in_byte),
    .req     (req)
  );

  u8u16_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (req),
    .rd   (rd),
    .full (full),
    .head (head)
  );

  u8u16_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .rd        (rd),
    .empty     (empty),
    .pop       (pop),
    .code_unit (code_unit),
    .last_unit (last_unit)
  );

endmodule

/* rtl/u8u16_checker.sv */
// Port-level checker for the transcoder, bound to the top level.
`include "assert_macros.svh"

module u8u16_checker (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic [7:0]  in_byte,
  input logic        empty,
  input logic        pop,
  input logic [15:0] code_unit,
  input logic        last_unit
);

  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, empty)
  `ASSERT_SAME(a_high_form, clk, rst, !empty && !last_unit, code_unit[15:10] == 6'b110110)
  `ASSERT_NEXT(a_pair, clk, rst, pop && !empty && !last_unit, !empty && last_unit && (code_unit[15:10] == 6'b110111))
  `ASSERT_NEXT(a_hold, clk, rst, !empty && !pop, !empty && $stable(code_unit) && $stable(last_unit))

endmodule

bind utf8_to_utf16_decoder u8u16_checker u_checker (.*);
